[design/vwt_pkg.sv]
`default_nettype none

package vwt_pkg;

  typedef enum logic [2:0] {
    CMD_ADD         = 3'd0,
    CMD_REMOVE      = 3'd1,
    CMD_REMOVE_ALL  = 3'd2,
    CMD_CLEAR_FLAGS = 3'd3,
    CMD_OBSERVE     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_DUPLICATE = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] param;
    logic [3:0]  target;
    logic [15:0] watch_value;
    logic [7:0]  evt;
  } entry_t;

endpackage

`default_nettype wire

[design/value_watch_table.sv]
`default_nettype none

// Channel | Ports                                                               | Accepted at
// --------+---------------------------------------------------------------------+---------------
// command | in_cmd, in_param_id, in_target, in_value, in_event_code             | start && !busy
// result  | out_event_valid, out_event_code_res, out_slot, out_status, out_last | out_strobe
//
// Add, remove and observe read one slot per cycle through the entry memory's single read
// port; their result strobe rises after the registered read and check of the last slot
// and the closing ST_FIN state. Other commands report in the cycle after the accept.
// busy is high from the accept of a walking command until its result is presented.
// Reset (rst_n low at a clock edge) empties the table and clears every fired flag.
// Each transaction yields exactly one result; the receiver cannot stall it.
module value_watch_table
  import vwt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [15:0] in_param_id,
  input  wire logic [3:0]  in_target,
  input  wire logic [15:0] in_value,
  input  wire logic [7:0]  in_event_code,
  output      logic        out_strobe,
  output      logic        out_event_valid,
  output      logic [7:0]  out_event_code_res,
  output      logic [3:0]  out_slot,
  output      logic [1:0]  out_status,
  output      logic        out_last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic issue_done_r, issue_done_nxt;
  logic chk_v_r, chk_v_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [ENTRIES-1:0] fired_r, fired_nxt;
  logic hit_found_r, hit_found_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic ev_found_r, ev_found_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic [7:0] ev_code_r, ev_code_nxt;

  cmd_t cmd_r, cmd_nxt;
  logic [15:0] pid_r, pid_nxt;
  logic [3:0] tgt_r, tgt_nxt;
  logic [15:0] val_r, val_nxt;
  logic [7:0] code_r, code_nxt;

  logic out_strobe_r, out_strobe_nxt;
  logic out_event_valid_r, out_event_valid_nxt;
  logic [7:0] out_code_r, out_code_nxt;
  logic [3:0] out_slot_r, out_slot_nxt;
  status_t out_status_r, out_status_nxt;

  entry_t mem [ENTRIES];
  entry_t mem_q_r;
  logic mem_we;

  logic accept;
  logic id_match;
  logic full_match;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  assign id_match = used_r[chk_idx_r] && (mem_q_r.param == pid_r) &&
                    (mem_q_r.target == tgt_r);
  assign full_match = id_match && (mem_q_r.watch_value == val_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx_r] <= '{param: pid_r, target: tgt_r, watch_value: val_r, evt: code_r};
    end
    mem_q_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt           = state_r;
    idx_nxt             = idx_r;
    issue_done_nxt      = issue_done_r;
    chk_v_nxt           = 1'b0;
    chk_idx_nxt         = idx_r;
    used_nxt            = used_r;
    fired_nxt           = fired_r;
    hit_found_nxt       = hit_found_r;
    hit_idx_nxt         = hit_idx_r;
    free_found_nxt      = free_found_r;
    free_idx_nxt        = free_idx_r;
    ev_found_nxt        = ev_found_r;
    ev_idx_nxt          = ev_idx_r;
    ev_code_nxt         = ev_code_r;
    cmd_nxt             = cmd_r;
    pid_nxt             = pid_r;
    tgt_nxt             = tgt_r;
    val_nxt             = val_r;
    code_nxt            = code_r;
    out_strobe_nxt      = 1'b0;
    out_event_valid_nxt = out_event_valid_r;
    out_code_nxt        = out_code_r;
    out_slot_nxt        = out_slot_r;
    out_status_nxt      = out_status_r;
    mem_we              = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = cmd_t'(in_cmd);
          pid_nxt  = in_param_id;
          tgt_nxt  = in_target;
          val_nxt  = in_value;
          code_nxt = in_event_code;
          // Quick commands report at once; the rest walk the table.
          out_strobe_nxt      = 1'b1;
          out_event_valid_nxt = 1'b0;
          out_code_nxt        = '0;
          out_slot_nxt        = '0;
          out_status_nxt      = STS_DONE;
          unique case (cmd_t'(in_cmd))
            CMD_ADD, CMD_REMOVE, CMD_OBSERVE: begin
              out_strobe_nxt = 1'b0;
              state_nxt      = ST_SCAN;
              idx_nxt        = '0;
              issue_done_nxt = 1'b0;
              hit_found_nxt  = 1'b0;
              free_found_nxt = 1'b0;
              ev_found_nxt   = 1'b0;
            end
            CMD_REMOVE_ALL: begin
              used_nxt  = '0;
              fired_nxt = '0;
            end
            CMD_CLEAR_FLAGS: begin
              fired_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue stage: one memory read per cycle.
        if (!issue_done_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // Check stage: the entry read in the previous cycle.
        if (chk_v_r) begin
          if (full_match) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = chk_idx_r;
          end
          if (!used_r[chk_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (cmd_r == CMD_OBSERVE && id_match) begin
            if (mem_q_r.watch_value == val_r) begin
              if (!fired_r[chk_idx_r]) begin
                fired_nxt[chk_idx_r] = 1'b1;
                if (!ev_found_r) begin
                  ev_found_nxt = 1'b1;
                  ev_idx_nxt   = chk_idx_r;
                  ev_code_nxt  = mem_q_r.evt;
                end
              end
            end else begin
              fired_nxt[chk_idx_r] = 1'b0;
            end
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        state_nxt           = ST_IDLE;
        out_strobe_nxt      = 1'b1;
        out_event_valid_nxt = 1'b0;
        out_code_nxt        = '0;
        out_slot_nxt        = '0;
        out_status_nxt      = STS_DONE;
        unique case (cmd_r)
          CMD_ADD: begin
            if (hit_found_r) begin
              out_slot_nxt   = 4'(hit_idx_r);
              out_status_nxt = STS_DUPLICATE;
            end else if (free_found_r) begin
              mem_we                  = 1'b1;
              used_nxt[free_idx_r]    = 1'b1;
              fired_nxt[free_idx_r]   = 1'b0;
              out_slot_nxt            = 4'(free_idx_r);
            end else begin
              out_status_nxt = STS_FULL;
            end
          end
          CMD_REMOVE: begin
            if (hit_found_r) begin
              used_nxt[hit_idx_r]  = 1'b0;
              fired_nxt[hit_idx_r] = 1'b0;
              out_slot_nxt         = 4'(hit_idx_r);
            end else begin
              out_status_nxt = STS_NOT_FOUND;
            end
          end
          CMD_OBSERVE: begin
            if (ev_found_r) begin
              out_event_valid_nxt = 1'b1;
              out_code_nxt        = ev_code_r;
              out_slot_nxt        = 4'(ev_idx_r);
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      chk_v_r      <= 1'b0;
      used_r       <= '0;
      fired_r      <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      ev_found_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      chk_v_r      <= chk_v_nxt;
      used_r       <= used_nxt;
      fired_r      <= fired_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      ev_found_r   <= ev_found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r         <= chk_idx_nxt;
    hit_idx_r         <= hit_idx_nxt;
    free_idx_r        <= free_idx_nxt;
    ev_idx_r          <= ev_idx_nxt;
    ev_code_r         <= ev_code_nxt;
    cmd_r             <= cmd_nxt;
    pid_r             <= pid_nxt;
    tgt_r             <= tgt_nxt;
    val_r             <= val_nxt;
    code_r            <= code_nxt;
    out_event_valid_r <= out_event_valid_nxt;
    out_code_r        <= out_code_nxt;
    out_slot_r        <= out_slot_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_event_valid    = out_event_valid_r;
  assign out_event_code_res = out_code_r;
  assign out_slot           = out_slot_r;
  assign out_status         = out_status_r;
  assign out_last           = 1'b1;

  // A walk never overlaps a pending result.
  a_no_strobe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !out_strobe_r)
    else $error("result strobe during a table walk");

  a_fin_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (out_strobe_r && state_r == ST_IDLE))
    else $error("finished walk did not report");

  a_add_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && cmd_r == CMD_ADD && !hit_found_r && free_found_r)
      |=> used_r[$past(free_idx_r)])
    else $error("added entry not marked used");

  a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_event_valid_r) |-> (out_status_r == STS_DONE))
    else $error("raised event with a failure status");

  a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_ADD || in_cmd == CMD_REMOVE || in_cmd == CMD_OBSERVE))
      |=> (state_r == ST_SCAN && !out_strobe_r))
    else $error("walking command did not start a walk");

endmodule

`default_nettype wire
